### hw/rtl/vector_projection_3d_unit_macros.svh
// Assertion macros used by the checker of the projection unit.
`ifndef VECTOR_PROJECTION_3D_UNIT_MACROS_SVH
`define VECTOR_PROJECTION_3D_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define VP3D_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vp3d assertion failed");

// Next-cycle implication, off while reset is asserted.
`define VP3D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vp3d assertion failed");

// Next-cycle implication that also covers reset itself.
`define VP3D_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("vp3d assertion failed");

`endif

### hw/rtl/vp3d_pkg.sv
package vp3d_pkg;

    localparam int unsigned CompW  = 32;
    localparam int unsigned NumDim = 3;
    localparam int unsigned ProdW  = 64;
    localparam int unsigned QuoW   = 31;
    localparam int unsigned FracW  = 16;
    localparam int unsigned InW    = 2 * NumDim * CompW;
    localparam int unsigned OutW   = NumDim * CompW;

    localparam logic [CompW-1:0] SatPos = 32'h7FFF_FFFF;
    localparam logic [CompW-1:0] SatNeg = 32'h8000_0000;

    typedef logic [CompW-1:0] comp_t;

    // One slot of the long-division pipeline.
    typedef struct packed {
        logic [ProdW-1:0] rem;
        logic [ProdW-1:0] dd;
        logic [QuoW-1:0]  num_low;
        logic [QuoW-1:0]  quo;
        logic             neg;
        logic             zero;
        logic             clip;
        logic             sat;
        comp_t [NumDim-1:0] dir;
    } div_stage_t;

    // Result sideband, zero_direction in bit 0.
    typedef struct packed {
        logic saturated;
        logic zero_direction;
    } out_flags_t;

endpackage

### hw/rtl/vector_projection_3d_unit.sv
// Projection of a 3-D vector v onto a direction d, signed Q16.16.
// Input channel s_*: one transaction carries vel_x/y/z and dir_x/y/z.
// Result channel m_*: proj_x/y/z in tdata, zero_direction and saturated in tuser.
// ratio = dot(v,d) * 2^16 / dot(d,d), truncated toward zero and clipped to 32
// bits; each component is (ratio * d_i) >> 16 (floor), clipped as well.
// A zero direction gives zero components and sets zero_direction.
// Throughput: one transaction per cycle while the output is not stalled.
// The pipeline is 39 register stages: operand magnitudes, six 32x32
// multiplies, dot sums, sign fold, range check, 31 restoring-division steps
// (one quotient bit per stage), ratio, three 32x32 multiplies and output.
// All stages advance together while the output register is empty or taken.
// When m_tready is low with a result waiting, the pipeline holds and one more
// input transaction is caught in a skid register; s_tready then drops.
// Reset (aresetn low, synchronous) clears all valid bits and the skid.
module vector_projection_3d_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // vel_x, vel_y, vel_z, dir_x, dir_y, dir_z (32 bits each, lowest first)
    input  logic [191:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // proj_x, proj_y, proj_z (32 bits each, lowest first)
    output logic [95:0]   m_tdata,
    // zero_direction, saturated
    output logic [1:0]    m_tuser
);

    localparam int unsigned Cw   = vp3d_pkg::CompW;
    localparam int unsigned Nd   = vp3d_pkg::NumDim;
    localparam int unsigned Pw   = vp3d_pkg::ProdW;
    localparam int unsigned Qw   = vp3d_pkg::QuoW;
    localparam int unsigned Fw   = vp3d_pkg::FracW;
    localparam int unsigned Sh   = Qw - Fw;

    logic en;
    logic s_acc;
    logic src_valid;
    logic [vp3d_pkg::InW-1:0] src_data;

    logic skid_valid_reg;
    logic [vp3d_pkg::InW-1:0] skid_data_reg;

    // stage A: magnitudes and signs
    logic a_valid_reg;
    logic [Cw-1:0] a_vmag_reg [Nd];
    logic [Cw-1:0] a_dmag_reg [Nd];
    logic [Nd-1:0] a_sgn_reg;
    vp3d_pkg::comp_t [Nd-1:0] a_dir_reg;
    logic [Cw-1:0] a_vmag_next [Nd];
    logic [Cw-1:0] a_dmag_next [Nd];
    logic [Nd-1:0] a_sgn_next;
    vp3d_pkg::comp_t [Nd-1:0] a_dir_next;

    // stage B: products
    logic b_valid_reg;
    logic [Pw-1:0] b_pm_reg [Nd];
    logic [Pw-1:0] b_dd_reg [Nd];
    logic [Nd-1:0] b_sgn_reg;
    vp3d_pkg::comp_t [Nd-1:0] b_dir_reg;

    // stage C: dot sums
    logic c_valid_reg;
    logic [Pw-1:0] c_pos_reg, c_neg_reg, c_dd_reg;
    logic [Pw-1:0] c_pos_next, c_neg_next, c_dd_next;
    vp3d_pkg::comp_t [Nd-1:0] c_dir_reg;

    // stage D: signed dot folded into magnitude and sign
    logic d_valid_reg;
    logic [Pw-1:0] d_mag_reg, d_dd_reg;
    logic [Pw-1:0] d_mag_next;
    logic d_neg_reg;
    vp3d_pkg::comp_t [Nd-1:0] d_dir_reg;

    // division pipeline
    logic [Qw:0] div_valid_reg;
    vp3d_pkg::div_stage_t div_reg  [Qw+1];
    vp3d_pkg::div_stage_t div_next [Qw+1];
    logic [Pw+Fw-2:0] ddsh;
    logic [Pw+Fw-2:0] magx;

    // stage R: ratio
    logic r_valid_reg;
    logic [Cw-1:0] r_ratio_reg, r_ratio_next;
    logic r_clip_reg, r_zero_reg;
    vp3d_pkg::comp_t [Nd-1:0] r_dir_reg;

    // stage M: ratio times direction
    logic mp_valid_reg;
    logic signed [Pw-1:0] mp_prod_reg [Nd];
    logic mp_clip_reg, mp_zero_reg;

    // stage O: output register
    logic o_valid_reg;
    vp3d_pkg::comp_t [Nd-1:0] o_proj_reg, o_proj_next;
    vp3d_pkg::out_flags_t o_flags_reg, o_flags_next;

    assign en        = m_tready | ~o_valid_reg;
    assign s_tready  = ~skid_valid_reg;
    assign s_acc     = s_tvalid & ~skid_valid_reg;
    assign src_valid = skid_valid_reg | s_acc;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (s_acc) begin
            skid_valid_reg <= 1'b1;
        end
        if (!en && s_acc) begin
            skid_data_reg <= s_tdata;
        end
    end

    always_comb begin
        for (int i = 0; i < Nd; i++) begin
            logic [Cw-1:0] v;
            logic [Cw-1:0] d;
            v = src_data[i*Cw +: Cw];
            d = src_data[(Nd+i)*Cw +: Cw];
            a_vmag_next[i] = v[Cw-1] ? (~v + 1'b1) : v;
            a_dmag_next[i] = d[Cw-1] ? (~d + 1'b1) : d;
            a_sgn_next[i]  = v[Cw-1] ^ d[Cw-1];
            a_dir_next[i]  = d;
        end
    end

    always_comb begin
        c_pos_next = '0;
        c_neg_next = '0;
        c_dd_next  = '0;
        for (int i = 0; i < Nd; i++) begin
            if (b_sgn_reg[i]) begin
                c_neg_next = c_neg_next + b_pm_reg[i];
            end else begin
                c_pos_next = c_pos_next + b_pm_reg[i];
            end
            c_dd_next = c_dd_next + b_dd_reg[i];
        end
    end

    assign d_mag_next = (c_pos_reg >= c_neg_reg) ? (c_pos_reg - c_neg_reg)
                                                 : (c_neg_reg - c_pos_reg);

    // range check and setup of the first division slot
    assign ddsh = {d_dd_reg, {Sh{1'b0}}};
    assign magx = {{Sh{1'b0}}, d_mag_reg};

    always_comb begin
        div_next[0].sat     = magx >= ddsh;
        div_next[0].clip    = d_neg_reg ? (magx > ddsh) : (magx >= ddsh);
        div_next[0].rem     = {{Sh{1'b0}}, d_mag_reg[Pw-1:Sh]};
        div_next[0].num_low = {d_mag_reg[Sh-1:0], {Fw{1'b0}}};
        div_next[0].quo     = '0;
        div_next[0].dd      = d_dd_reg;
        div_next[0].neg     = d_neg_reg;
        div_next[0].zero    = (d_dd_reg == '0);
        div_next[0].dir     = d_dir_reg;
    end

    for (genvar k = 0; k < Qw; k++) begin : g_div
        logic [Pw:0] trial;
        logic [Pw:0] diff;
        logic        ge;
        assign trial = {div_reg[k].rem, div_reg[k].num_low[Qw-1]};
        assign diff  = trial - {1'b0, div_reg[k].dd};
        assign ge    = trial >= {1'b0, div_reg[k].dd};
        always_comb begin
            div_next[k+1]         = div_reg[k];
            div_next[k+1].rem     = ge ? diff[Pw-1:0] : trial[Pw-1:0];
            div_next[k+1].num_low = {div_reg[k].num_low[Qw-2:0], 1'b0};
            div_next[k+1].quo     = {div_reg[k].quo[Qw-2:0], ge};
        end
    end

    always_comb begin
        if (div_reg[Qw].sat) begin
            r_ratio_next = div_reg[Qw].neg ? vp3d_pkg::SatNeg : vp3d_pkg::SatPos;
        end else if (div_reg[Qw].neg) begin
            r_ratio_next = ~{1'b0, div_reg[Qw].quo} + 1'b1;
        end else begin
            r_ratio_next = {1'b0, div_reg[Qw].quo};
        end
    end

    always_comb begin
        o_flags_next.zero_direction = mp_zero_reg;
        o_flags_next.saturated      = 1'b0;
        for (int i = 0; i < Nd; i++) begin
            logic [Pw-Fw-Cw:0] hi;
            logic              in_range;
            hi       = mp_prod_reg[i][Pw-1:Fw+Cw-1];
            in_range = (hi == '0) || (hi == '1);
            if (mp_zero_reg) begin
                o_proj_next[i] = '0;
            end else if (in_range) begin
                o_proj_next[i] = mp_prod_reg[i][Fw+Cw-1:Fw];
            end else begin
                o_proj_next[i] = mp_prod_reg[i][Pw-1] ? vp3d_pkg::SatNeg : vp3d_pkg::SatPos;
            end
            if (!mp_zero_reg && !in_range) begin
                o_flags_next.saturated = 1'b1;
            end
        end
        if (!mp_zero_reg && mp_clip_reg) begin
            o_flags_next.saturated = 1'b1;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            div_valid_reg <= '0;
            r_valid_reg   <= 1'b0;
            mp_valid_reg  <= 1'b0;
            o_valid_reg   <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= src_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= c_valid_reg;
            div_valid_reg <= {div_valid_reg[Qw-1:0], d_valid_reg};
            r_valid_reg   <= div_valid_reg[Qw];
            mp_valid_reg  <= r_valid_reg;
            o_valid_reg   <= mp_valid_reg;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < Nd; i++) begin
                a_vmag_reg[i] <= a_vmag_next[i];
                a_dmag_reg[i] <= a_dmag_next[i];
                b_pm_reg[i]   <= a_vmag_reg[i] * a_dmag_reg[i];
                b_dd_reg[i]   <= a_dmag_reg[i] * a_dmag_reg[i];
                mp_prod_reg[i] <= $signed(r_ratio_reg) * $signed(r_dir_reg[i]);
            end
            a_sgn_reg   <= a_sgn_next;
            a_dir_reg   <= a_dir_next;
            b_sgn_reg   <= a_sgn_reg;
            b_dir_reg   <= a_dir_reg;
            c_pos_reg   <= c_pos_next;
            c_neg_reg   <= c_neg_next;
            c_dd_reg    <= c_dd_next;
            c_dir_reg   <= b_dir_reg;
            d_mag_reg   <= d_mag_next;
            d_neg_reg   <= c_pos_reg < c_neg_reg;
            d_dd_reg    <= c_dd_reg;
            d_dir_reg   <= c_dir_reg;
            for (int k = 0; k <= Qw; k++) begin
                div_reg[k] <= div_next[k];
            end
            r_ratio_reg <= r_ratio_next;
            r_clip_reg  <= div_reg[Qw].clip;
            r_zero_reg  <= div_reg[Qw].zero;
            r_dir_reg   <= div_reg[Qw].dir;
            mp_clip_reg <= r_clip_reg;
            mp_zero_reg <= r_zero_reg;
            o_proj_reg  <= o_proj_next;
            o_flags_reg <= o_flags_next;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_proj_reg;
    assign m_tuser  = o_flags_reg;

endmodule

### hw/rtl/vp3d_checker.sv
`include "vector_projection_3d_unit_macros.svh"

module vp3d_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [191:0]  s_tdata,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [95:0]   m_tdata,
    input logic [1:0]    m_tuser
);

    `VP3D_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `VP3D_ASSERT_IMPL(a_zero_dir, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata == 96'd0 && !m_tuser[1])
    `VP3D_ASSERT_IMPL(a_skid_fill, aclk, aresetn, $fell(s_tready), $past(m_tvalid && !m_tready && s_tvalid))
    `VP3D_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind vector_projection_3d_unit vp3d_checker u_vp3d_checker (.*);
